// ===== hdl/kfd_pkg.sv =====
// Package for the KISS receive deframer: framing byte codes, decode mode codes,
// result event codes and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package kfd_pkg;

   localparam int ByteWidth   = 8;
   localparam int KindWidth   = 2;
   localparam int LenWidth    = 12;
   localparam int CfgWidth    = 12;
   localparam int ModeWidth   = 2;

   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 24;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [KindWidth-1:0] kind_type;
   typedef logic [ModeWidth-1:0] mode_type;

   localparam byte_type FEND  = 8'hC0;
   localparam byte_type FESC  = 8'hDB;
   localparam byte_type TFEND = 8'hDC;
   localparam byte_type TFESC = 8'hDD;
   localparam byte_type ZERO_BYTE = 8'h00;

   localparam mode_type MODE_WAIT = 2'd0;
   localparam mode_type MODE_IN   = 2'd1;
   localparam mode_type MODE_ESC  = 2'd2;
   localparam mode_type MODE_SKIP = 2'd3;

   localparam kind_type EV_PAYLOAD  = 2'd0;
   localparam kind_type EV_DONE     = 2'd1;
   localparam kind_type EV_OVERFLOW = 2'd2;
   localparam kind_type EV_DROP     = 2'd3;

   localparam logic [CfgWidth-1:0] MAX_LEN_RESET = 12'd256;

endpackage

// ===== hdl/kiss_frame_decoder.sv =====
// KISS receive deframer: one received byte per word in, at most one event word out.
// Results are registered; one word is taken per cycle unless its result is stalled.
// The byte decode, buffer claim and length check sit between the input and result registers.
// The mode updates as each word advances, so back-to-back words are accepted while no result stalls.
// Synchronous active-high reset returns to waiting for a frame start with no buffer held
// and sets the length limit to 256. Depends on kfd_pkg.
`timescale 1ns / 1ps

module kiss_frame_decoder
   import kfd_pkg::*;
#(
   parameter int LENGTH_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,   // rx_byte[7:0], buffer_ready[8], zero fill
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // payload_byte[7:0], frame_len[19:8], zero fill
   output logic [KindWidth-1:0]    rsp_tuser,   // event_kind[1:0]
   input  logic                    csr_we,
   input  logic [CfgWidth-1:0]     csr_wdata
);

   localparam int CmpWidth = (LENGTH_BITS > CfgWidth) ? LENGTH_BITS : CfgWidth;
   localparam logic [CmpWidth-1:0] COUNT_MAX = CmpWidth'({LENGTH_BITS{1'b1}});

   logic [CfgWidth-1:0]    max_len_ff;
   logic                   in_valid_ff;
   byte_type               in_byte_ff;
   logic                   in_ready_ff;
   mode_type               mode_ff, mode_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   skip_ff, skip_in;
   logic                   held_ff, held_in;
   logic                   out_valid_ff;
   kind_type               out_kind_ff;
   byte_type               out_byte_ff;
   logic [LenWidth-1:0]    out_len_ff;

   logic                   advance;
   logic                   has_res;
   kind_type               res_kind;
   byte_type               res_byte;
   logic [LenWidth-1:0]    res_len;
   logic [CmpWidth-1:0]    limit;
   logic                   full;
   logic                   out_free;

   assign limit = (CmpWidth'(max_len_ff) > COUNT_MAX) ? COUNT_MAX : CmpWidth'(max_len_ff);
   assign full  = held_ff && (CmpWidth'(count_ff) >= limit);

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      skip_in  = skip_ff;
      held_in  = held_ff;
      has_res  = 1'b0;
      res_kind = EV_PAYLOAD;
      res_byte = ZERO_BYTE;
      res_len  = '0;
      if (full) begin
         has_res  = 1'b1;
         res_kind = EV_OVERFLOW;
         mode_in  = MODE_WAIT;
         count_in = '0;
      end
      case (mode_in)
         MODE_WAIT: begin
            if (in_byte_ff == FEND) begin
               if (!held_ff && !in_ready_ff) begin
                  mode_in  = MODE_SKIP;
                  has_res  = 1'b1;
                  res_kind = EV_DROP;
               end else begin
                  held_in  = 1'b1;
                  count_in = '0;
                  mode_in  = MODE_IN;
                  skip_in  = 1'b1;
               end
            end
         end
         MODE_IN: begin
            if (in_byte_ff == FESC) begin
               mode_in = MODE_ESC;
            end else if (in_byte_ff == FEND) begin
               if (count_ff != '0) begin
                  has_res  = 1'b1;
                  res_kind = EV_DONE;
                  res_len  = LenWidth'(count_ff);
                  held_in  = 1'b0;
                  mode_in  = MODE_WAIT;
               end
            end else if (skip_ff) begin
               skip_in = 1'b0;
            end else begin
               has_res  = 1'b1;
               res_byte = in_byte_ff;
               count_in = count_ff + LENGTH_BITS'(1);
            end
         end
         MODE_ESC: begin
            if (in_byte_ff == TFESC) begin
               has_res  = 1'b1;
               res_byte = FESC;
               count_in = count_ff + LENGTH_BITS'(1);
            end else if (in_byte_ff == TFEND) begin
               has_res  = 1'b1;
               res_byte = FEND;
               count_in = count_ff + LENGTH_BITS'(1);
            end
            mode_in = MODE_IN;
         end
         default: begin
            if (in_byte_ff == FEND) begin
               mode_in = MODE_WAIT;
            end
         end
      endcase
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!has_res || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         max_len_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata[ByteWidth-1:0];
         in_ready_ff <= req_tdata[ByteWidth];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WAIT;
         count_ff <= '0;
         skip_ff  <= 1'b0;
         held_ff  <= 1'b0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         skip_ff  <= skip_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && has_res) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && has_res) begin
         out_kind_ff <= res_kind;
         out_byte_ff <= res_byte;
         out_len_ff  <= res_len;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {{(RspDataWidth - ByteWidth - LenWidth){1'b0}}, out_len_ff, out_byte_ff};

   a_skip_no_buffer: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SKIP |-> !held_ff)
      else $error("skipping a frame while a buffer is held");

   a_frame_has_buffer: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IN || mode_ff == MODE_ESC) |-> held_ff)
      else $error("inside a frame without a buffer");

   a_done_nonempty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == EV_DONE) |-> out_len_ff != '0)
      else $error("frame complete reported with zero length");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && has_res) |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten while stalled");

endmodule
